[hdl/ssi_pkg.sv]
// Shared types, constants and phase logic for the stepper sector indexer.
`default_nettype none
package ssi_pkg;

   // Configuration of the block
   localparam int MOTOR_COUNT = 4;
   localparam int COUNT_BITS  = 16;

   // Motor limit wide enough for any motor count in range
   localparam int MOTOR_LIMIT_BITS = 5;
   localparam logic [MOTOR_LIMIT_BITS-1:0] MOTOR_LIMIT = MOTOR_LIMIT_BITS'(MOTOR_COUNT);

   // Fixed field widths
   localparam int MOTOR_BITS   = 2;
   localparam int FIELD_COUNT_BITS = 16;
   localparam int SPEED_BITS   = 8;
   localparam int SENSOR_BITS  = 4;
   localparam int BACKOFF_BITS = 8;
   localparam logic [BACKOFF_BITS-1:0] BACKOFF_RESET = 8'd8;

   // Item kinds
   localparam logic KIND_COMMAND = 1'b0;
   localparam logic KIND_TICK    = 1'b1;

   // Sequencer phases
   localparam int PHASE_BITS = 4;
   localparam logic [PHASE_BITS-1:0] PH_IDLE       = 4'd0;
   localparam logic [PHASE_BITS-1:0] PH_STEP       = 4'd1;
   localparam logic [PHASE_BITS-1:0] PH_SEEK_START = 4'd2;
   localparam logic [PHASE_BITS-1:0] PH_SEEK_FREE  = 4'd3;
   localparam logic [PHASE_BITS-1:0] PH_SEC_ECL    = 4'd4;
   localparam logic [PHASE_BITS-1:0] PH_SEC_FREE   = 4'd5;
   localparam logic [PHASE_BITS-1:0] PH_BACKOFF    = 4'd6;

   typedef logic [COUNT_BITS-1:0]   count_type;
   typedef logic [BACKOFF_BITS-1:0] backoff_type;
   typedef logic [PHASE_BITS-1:0]   phase_type;

   // One input item as held in the input register
   typedef struct packed {
      logic                        kind;
      logic [MOTOR_BITS-1:0]       motor_index;
      logic                        turn_direction;
      logic                        sector_mode;
      logic [FIELD_COUNT_BITS-1:0] count;
      logic [SPEED_BITS-1:0]       step_rate;
      logic [SENSOR_BITS-1:0]      sensor_levels;
   } item_type;

   // One result item
   typedef struct packed {
      logic                  step_pulse;
      logic [MOTOR_BITS-1:0] step_motor_index;
      logic                  step_direction;
      logic [SPEED_BITS-1:0] step_speed;
      logic                  finished;
   } result_type;

   // Resolve phases that need no sensor reading
   function automatic phase_type settle(phase_type ph, count_type rem, backoff_type bo);
      phase_type p;
      p = ph;
      if (p == PH_SEC_ECL && rem == '0) p = PH_BACKOFF;
      if (p == PH_BACKOFF && bo == '0) p = PH_IDLE;
      if (p == PH_STEP && rem == '0) p = PH_IDLE;
      return p;
   endfunction

endpackage
`default_nettype wire

[hdl/ssi_in_reg.sv]
// Input register: holds one accepted request item until the sequencer takes it.
`default_nettype none
module ssi_in_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ssi_pkg::item_type req_item,
   input  wire logic              take,
   output logic                   item_valid,
   output ssi_pkg::item_type      item
);
   import ssi_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;

   // Accept whenever the slot is empty or drains this cycle
   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (take) valid_in = 1'b0;
      if (req_valid && req_ready) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the item payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
endmodule
`default_nettype wire

[hdl/ssi_seq.sv]
// Rotation sequencer: phase state, counters and the step decision per item.
`default_nettype none
module ssi_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 go,
   input  wire ssi_pkg::item_type    item,
   input  wire ssi_pkg::backoff_type backoff_steps,
   output logic                      emit,
   output ssi_pkg::result_type       result
);
   import ssi_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [MOTOR_BITS-1:0] motor_ff, motor_in;
   logic                  dir_ff, dir_in;
   logic [SPEED_BITS-1:0] speed_ff, speed_in;
   count_type             remaining_ff, remaining_in;
   backoff_type           backoff_left_ff, backoff_left_in;

   logic      is_free;
   logic      step_dir;
   phase_type eff_phase;
   phase_type next_phase;
   count_type rem_next;
   backoff_type bo_next;

   // Sensor of the active motor
   assign is_free = item.sensor_levels[motor_ff];

   // Lead-in skipped when the sensor already reads eclipsed
   assign eff_phase = (phase_ff == PH_SEEK_START && !is_free)
                      ? settle(PH_SEC_ECL, remaining_ff, backoff_left_ff) : phase_ff;

   // Decide the step of a tick
   always_comb begin
      emit       = 1'b1;
      step_dir   = dir_ff;
      next_phase = eff_phase;
      rem_next   = remaining_ff;
      bo_next    = backoff_left_ff;
      unique case (eff_phase)
         PH_STEP: begin
            rem_next = remaining_ff - 1'b1;
         end
         PH_SEEK_START: begin
            next_phase = PH_SEEK_FREE;
         end
         PH_SEEK_FREE: begin
            if (!is_free) next_phase = PH_SEC_ECL;
         end
         PH_SEC_ECL: begin
            if (is_free) next_phase = PH_SEC_FREE;
         end
         PH_SEC_FREE: begin
            if (!is_free) begin
               rem_next   = remaining_ff - 1'b1;
               next_phase = PH_SEC_ECL;
            end
         end
         PH_BACKOFF: begin
            bo_next  = backoff_left_ff - 1'b1;
            step_dir = !dir_ff;
         end
         default: begin
            emit       = 1'b0;
            next_phase = PH_IDLE;
         end
      endcase
      if (emit) next_phase = settle(next_phase, rem_next, bo_next);
   end

   // Update state for the item being taken
   always_comb begin
      phase_in        = phase_ff;
      motor_in        = motor_ff;
      dir_in          = dir_ff;
      speed_in        = speed_ff;
      remaining_in    = remaining_ff;
      backoff_left_in = backoff_left_ff;
      if (go) begin
         if (item.kind == KIND_COMMAND) begin
            if (phase_ff == PH_IDLE && {3'd0, item.motor_index} < MOTOR_LIMIT) begin
               motor_in        = item.motor_index;
               dir_in          = item.turn_direction;
               speed_in        = item.step_rate;
               remaining_in    = count_type'(item.count);
               backoff_left_in = backoff_steps;
               phase_in        = settle(item.sector_mode ? PH_SEEK_START : PH_STEP,
                                        count_type'(item.count), backoff_steps);
            end
         end else if (phase_ff != PH_IDLE) begin
            phase_in        = next_phase;
            remaining_in    = rem_next;
            backoff_left_in = bo_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         motor_ff        <= '0;
         dir_ff          <= 1'b0;
         speed_ff        <= '0;
         remaining_ff    <= '0;
         backoff_left_ff <= '0;
      end else begin
         phase_ff        <= phase_in;
         motor_ff        <= motor_in;
         dir_ff          <= dir_in;
         speed_ff        <= speed_in;
         remaining_ff    <= remaining_in;
         backoff_left_ff <= backoff_left_in;
      end
   end

   // Result of a tick that issues a step
   always_comb begin
      result.step_pulse       = 1'b1;
      result.step_motor_index = motor_ff;
      result.step_direction   = step_dir;
      result.step_speed       = speed_ff;
      result.finished         = (next_phase == PH_IDLE);
   end
endmodule
`default_nettype wire

[hdl/stepper_sector_indexer.sv]
// Top level of the stepper sector indexer: ports, backoff register, result register.
//
// Request channel (req_*): command items (kind 0) start a rotation of one motor,
// tick items (kind 1) carry the four slot sensor levels and may issue one step.
// Result channel (rsp_*): one item per tick that issues a step, carrying motor,
// direction (inverted during backoff), speed and a finished flag on the last step.
// Commands, idle ticks and ticks that issue no step give no result item.
// CSR channel (csr_*): writes backoff_steps; it is latched when a command starts.
// Write it only while no rotation is running. csr_ready is always high.
//
// A result passes through two registers: the input register captures its request
// when it is accepted, and the result register loads once it is free. Throughput:
// one item per cycle while the receiver does not stall, as the phase decision and
// counter update fit between the two registers.
// A stalled receiver holds the result register; the input register still takes
// one more item, then req_ready drops until the result is taken.
// Reset: synchronous, active high; the block is idle, backoff_steps is 8.
`default_nettype none
module stepper_sector_indexer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic [1:0]  req_motor_index,
   input  wire logic        req_turn_direction,
   input  wire logic        req_sector_mode,
   input  wire logic [15:0] req_count,
   input  wire logic [7:0]  req_step_rate,
   input  wire logic [3:0]  req_sensor_levels,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_step_pulse,
   output logic [1:0]       rsp_step_motor_index,
   output logic             rsp_step_direction,
   output logic [7:0]       rsp_step_speed,
   output logic             rsp_finished,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_backoff_steps
);
   import ssi_pkg::*;

   item_type    req_item;
   item_type    item;
   logic        item_valid;
   logic        take;
   logic        out_free;
   logic        emit;
   result_type  result;
   backoff_type backoff_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff;

   assign req_item.kind           = req_kind;
   assign req_item.motor_index    = req_motor_index;
   assign req_item.turn_direction = req_turn_direction;
   assign req_item.sector_mode    = req_sector_mode;
   assign req_item.count          = req_count;
   assign req_item.step_rate      = req_step_rate;
   assign req_item.sensor_levels  = req_sensor_levels;

   // Advance an item when the result register can take a new value
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign take     = item_valid && out_free;

   ssi_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   ssi_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .go            (take),
      .item          (item),
      .backoff_steps (backoff_ff),
      .emit          (emit),
      .result        (result)
   );

   // Backoff register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         backoff_ff <= BACKOFF_RESET;
      end else if (csr_valid) begin
         backoff_ff <= csr_backoff_steps;
      end
   end

   // Result register: load on a step, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (take && item.kind == KIND_TICK && emit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_step_pulse       = rsp_ff.step_pulse;
   assign rsp_step_motor_index = rsp_ff.step_motor_index;
   assign rsp_step_direction   = rsp_ff.step_direction;
   assign rsp_step_speed       = rsp_ff.step_speed;
   assign rsp_finished         = rsp_ff.finished;
endmodule
`default_nettype wire

[tb/stepper_sector_indexer_tb.sv]
// Self-checking testbench for the stepper sector indexer: directed table, then random rotations.
`timescale 1ns / 1ps
module stepper_sector_indexer_tb;
   import ssi_pkg::*;

   localparam longint RUN_LIMIT_NS = 8_000_000;
   localparam int     SETTLE_CYCLES = 6;
   localparam int     RANDOM_ITEMS = 1450;
   localparam int     PRESSURE_CYCLES = 400;

   // How a directed row is checked, or whether it writes the backoff register
   typedef enum logic [1:0] {BY_MODEL, WANT_NONE, WANT_STEP, CSR_WRITE} row_kind_type;

   typedef struct {
      row_kind_type how;
      logic         kind;
      logic [1:0]   motor;
      logic         turn;
      logic         sector;
      logic [15:0]  count;
      logic [7:0]   rate;
      logic [3:0]   sensors;
      result_type   want;
      logic [7:0]   backoff;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid;
   logic        req_ready;
   logic        req_kind;
   logic [1:0]  req_motor_index;
   logic        req_turn_direction;
   logic        req_sector_mode;
   logic [15:0] req_count;
   logic [7:0]  req_step_rate;
   logic [3:0]  req_sensor_levels;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_step_pulse;
   logic [1:0]  rsp_step_motor_index;
   logic        rsp_step_direction;
   logic [7:0]  rsp_step_speed;
   logic        rsp_finished;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_backoff_steps;

   // Sequencer state as predicted
   phase_type   seq_phase = PH_IDLE;
   logic [1:0]  seq_motor = '0;
   logic        seq_turn = 1'b0;
   logic [7:0]  seq_speed = '0;
   count_type   steps_left = '0;
   backoff_type backoff_left = '0;
   backoff_type backoff_cfg = BACKOFF_RESET;

   result_type  expected_steps[$];
   int          fail_count = 0;
   int          results_seen = 0;
   int          items_sent = 0;
   int          random_items = 0;
   int          next_hold_at = 150;
   int          holds_done = 0;

   dir_row_type directed_rows [24] = '{
      // tick while idle right after reset
      '{WANT_NONE, KIND_TICK, 2'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 4'hF, '0, 8'h00},
      // step mode with zero count: no step at all
      '{WANT_NONE, KIND_COMMAND, 2'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 4'h0, '0, 8'h00},
      '{WANT_NONE, KIND_TICK, 2'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 4'h0, '0, 8'h00},
      // two plain steps on the top motor at full rate
      '{WANT_NONE, KIND_COMMAND, 2'd3, 1'b1, 1'b0, 16'd2, 8'hFF, 4'h0, '0, 8'h00},
      '{WANT_STEP, KIND_TICK, 2'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 4'h0,
        '{1'b1, 2'd3, 1'b1, 8'hFF, 1'b0}, 8'h00},
      '{WANT_STEP, KIND_TICK, 2'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 4'hF,
        '{1'b1, 2'd3, 1'b1, 8'hFF, 1'b1}, 8'h00},
      // sector mode, zero sectors, zero backoff, eclipsed at start: silent
      '{CSR_WRITE, KIND_TICK, 2'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 4'h0, '0, 8'h00},
      '{WANT_NONE, KIND_COMMAND, 2'd2, 1'b1, 1'b1, 16'd0, 8'h81, 4'hF, '0, 8'h00},
      '{WANT_NONE, KIND_TICK, 2'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 4'b1011, '0, 8'h00},
      '{WANT_NONE, KIND_TICK, 2'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 4'h0, '0, 8'h00},
      // one sector with lead-in and two backoff steps; command while busy is dropped
      '{CSR_WRITE, KIND_TICK, 2'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 4'h0, '0, 8'd2},
      '{WANT_NONE, KIND_COMMAND, 2'd1, 1'b0, 1'b1, 16'd1, 8'h5A, 4'h0, '0, 8'h00},
      '{WANT_NONE, KIND_COMMAND, 2'd2, 1'b1, 1'b0, 16'hFFFF, 8'h00, 4'h0, '0, 8'h00},
      '{BY_MODEL, KIND_TICK, 2'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 4'b0010, '0, 8'h00},
      '{BY_MODEL, KIND_TICK, 2'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 4'b0010, '0, 8'h00},
      '{BY_MODEL, KIND_TICK, 2'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 4'b0000, '0, 8'h00},
      '{BY_MODEL, KIND_TICK, 2'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 4'b0000, '0, 8'h00},
      '{BY_MODEL, KIND_TICK, 2'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 4'b0010, '0, 8'h00},
      '{BY_MODEL, KIND_TICK, 2'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 4'b1101, '0, 8'h00},
      '{BY_MODEL, KIND_TICK, 2'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 4'b1111, '0, 8'h00},
      '{BY_MODEL, KIND_TICK, 2'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 4'b0000, '0, 8'h00},
      // fields of the other item kind carry extreme values and are ignored
      '{CSR_WRITE, KIND_TICK, 2'd0, 1'b0, 1'b0, 16'h0000, 8'h00, 4'h0, '0, 8'hFF},
      '{WANT_NONE, KIND_COMMAND, 2'd0, 1'b1, 1'b0, 16'd1, 8'h01, 4'hF, '0, 8'h00},
      '{WANT_STEP, KIND_TICK, 2'd3, 1'b0, 1'b1, 16'hFFFF, 8'hFF, 4'h0,
        '{1'b1, 2'd0, 1'b1, 8'h01, 1'b1}, 8'h00}
   };

   stepper_sector_indexer DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_motor_index      (req_motor_index),
      .req_turn_direction   (req_turn_direction),
      .req_sector_mode      (req_sector_mode),
      .req_count            (req_count),
      .req_step_rate        (req_step_rate),
      .req_sensor_levels    (req_sensor_levels),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_step_pulse       (rsp_step_pulse),
      .rsp_step_motor_index (rsp_step_motor_index),
      .rsp_step_direction   (rsp_step_direction),
      .rsp_step_speed       (rsp_step_speed),
      .rsp_finished         (rsp_finished),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_backoff_steps    (csr_backoff_steps)
   );

   always #5 clock = ~clock;

   // Advance through phases that need no sensor reading
   function automatic void resolve_idle_phases();
      if (seq_phase == PH_SEC_ECL && steps_left == '0) seq_phase = PH_BACKOFF;
      if (seq_phase == PH_BACKOFF && backoff_left == '0) seq_phase = PH_IDLE;
      if (seq_phase == PH_STEP && steps_left == '0) seq_phase = PH_IDLE;
   endfunction

   // Apply one item to the predicted sequencer; return 1 when it issues a step
   function automatic bit advance_indexer(input item_type it, output result_type res);
      logic slot_free;
      logic turn;
      res = '0;
      if (it.kind == KIND_COMMAND) begin
         if (seq_phase != PH_IDLE || int'(it.motor_index) >= MOTOR_COUNT) return 1'b0;
         seq_motor = it.motor_index;
         seq_turn = it.turn_direction;
         steps_left = count_type'(it.count);
         seq_speed = it.step_rate;
         backoff_left = backoff_cfg;
         seq_phase = it.sector_mode ? PH_SEEK_START : PH_STEP;
         resolve_idle_phases();
         return 1'b0;
      end
      if (seq_phase == PH_IDLE) return 1'b0;
      slot_free = it.sensor_levels[seq_motor];
      turn = seq_turn;
      // skip the lead-in when the slot is already eclipsed
      if (seq_phase == PH_SEEK_START && !slot_free) begin
         seq_phase = PH_SEC_ECL;
         resolve_idle_phases();
      end
      case (seq_phase)
         PH_STEP: steps_left = steps_left - 1'b1;
         PH_SEEK_START: seq_phase = PH_SEEK_FREE;
         PH_SEEK_FREE: if (!slot_free) seq_phase = PH_SEC_ECL;
         PH_SEC_ECL: if (slot_free) seq_phase = PH_SEC_FREE;
         PH_SEC_FREE: if (!slot_free) begin
            steps_left = steps_left - 1'b1;
            seq_phase = PH_SEC_ECL;
         end
         PH_BACKOFF: begin
            backoff_left = backoff_left - 1'b1;
            turn = ~seq_turn;
         end
         default: begin
            seq_phase = PH_IDLE;
            return 1'b0;
         end
      endcase
      res.step_pulse = 1'b1;
      res.step_motor_index = seq_motor;
      res.step_direction = turn;
      res.step_speed = seq_speed;
      resolve_idle_phases();
      res.finished = (seq_phase == PH_IDLE);
      return 1'b1;
   endfunction

   // Idle length: mostly none or short, a few long
   function automatic int idle_span(input bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 9);
      return $urandom_range(10, 40);
   endfunction

   function automatic item_type random_item(input logic kind);
      item_type it;
      it.kind = kind;
      it.motor_index = 2'($urandom);
      it.turn_direction = 1'($urandom);
      it.sector_mode = 1'($urandom);
      it.count = 16'($urandom);
      it.step_rate = 8'($urandom);
      it.sensor_levels = 4'($urandom);
      return it;
   endfunction

   // Offer one item, hold it until accepted, then predict its effect
   task automatic offer_item(input item_type it, output bit stepped, output result_type res,
                             output bit counts);
      int gap;
      gap = idle_span((items_sent / 50) % 4 == 0);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_kind <= it.kind;
      req_motor_index <= it.motor_index;
      req_turn_direction <= it.turn_direction;
      req_sector_mode <= it.sector_mode;
      req_count <= it.count;
      req_step_rate <= it.step_rate;
      req_sensor_levels <= it.sensor_levels;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      counts = (seq_phase != PH_IDLE) == (it.kind == KIND_TICK);
      stepped = advance_indexer(it, res);
   endtask

   task automatic feed(input item_type it);
      bit stepped;
      bit counts;
      result_type res;
      offer_item(it, stepped, res, counts);
      if (stepped) expected_steps.push_back(res);
      if (counts) random_items++;
   endtask

   // Drop valid and wait until every step has come out and the pipeline is quiet
   task automatic drain_steps();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_steps.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_backoff(input backoff_type value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_backoff_steps <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      backoff_cfg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One command followed by ticks until the rotation ends
   task automatic run_rotation();
      item_type it;
      logic     slot_free;
      int       pick;
      int       flip_odds;
      it = random_item(KIND_COMMAND);
      pick = $urandom_range(0, 99);
      if (it.sector_mode) begin
         it.count = (pick < 85) ? 16'($urandom_range(0, 3)) : 16'($urandom_range(4, 10));
      end
      else if (pick < 85) it.count = 16'($urandom_range(0, 10));
      else if (pick < 96) it.count = 16'($urandom_range(11, 60));
      else it.count = 16'($urandom_range(100, 300));
      feed(it);
      slot_free = 1'($urandom);
      flip_odds = ($urandom_range(0, 4) == 0) ? 15 : 2;
      while (seq_phase != PH_IDLE) begin
         if ($urandom_range(0, 39) == 0) feed(random_item(KIND_COMMAND));
         it = random_item(KIND_TICK);
         if ($urandom_range(0, flip_odds) == 0) slot_free = ~slot_free;
         it.sensor_levels[seq_motor] = slot_free;
         feed(it);
      end
   endtask

   // Check each step item against the oldest prediction
   always @(posedge clock) begin : check_steps
      result_type want;
      result_type got;
      got = {rsp_step_pulse, rsp_step_motor_index, rsp_step_direction, rsp_step_speed,
             rsp_finished};
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_steps.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: unexpected step: pulse %0d motor %0d dir %0d speed %0d fin %0d",
                        $realtime, got.step_pulse, got.step_motor_index, got.step_direction,
                        got.step_speed, got.finished);
         end else begin
            want = expected_steps.pop_front();
            if (got.step_pulse !== want.step_pulse
                || got.step_motor_index !== want.step_motor_index
                || got.step_direction !== want.step_direction
                || got.step_speed !== want.step_speed
                || got.finished !== want.finished) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: mismatch: expected pulse %0d motor %0d dir %0d speed %0d fin %0d",
                           $realtime, want.step_pulse, want.step_motor_index,
                           want.step_direction, want.step_speed, want.finished);
                  $display("   got pulse %0d motor %0d dir %0d speed %0d fin %0d",
                           got.step_pulse, got.step_motor_index, got.step_direction,
                           got.step_speed, got.finished);
               end
            end
         end
      end
   end

   // Receiver: random stalls, plus long hold-offs that back the block up
   initial begin : take_steps
      int hold;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (holds_done < 2 && results_seen >= next_hold_at) begin
            rsp_ready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(negedge clock);
            holds_done++;
            next_hold_at = results_seen + 550;
         end else begin
            hold = idle_span((results_seen / 64) % 3 == 0);
            if (hold > 0) begin
               rsp_ready <= 1'b0;
               repeat (hold) @(negedge clock);
            end
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
   end

   initial begin : stimulus
      item_type    it;
      result_type  res;
      bit          stepped;
      bit          counts;
      int          phase_no;
      int          phase_end;
      backoff_type bo;
      req_valid = 1'b0;
      req_kind = KIND_COMMAND;
      req_motor_index = '0;
      req_turn_direction = 1'b0;
      req_sector_mode = 1'b0;
      req_count = '0;
      req_step_rate = '0;
      req_sensor_levels = '0;
      csr_valid = 1'b0;
      csr_backoff_steps = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].how == CSR_WRITE) begin
            drain_steps();
            write_backoff(directed_rows[i].backoff);
         end else begin
            it.kind = directed_rows[i].kind;
            it.motor_index = directed_rows[i].motor;
            it.turn_direction = directed_rows[i].turn;
            it.sector_mode = directed_rows[i].sector;
            it.count = directed_rows[i].count;
            it.step_rate = directed_rows[i].rate;
            it.sensor_levels = directed_rows[i].sensors;
            offer_item(it, stepped, res, counts);
            if (directed_rows[i].how == WANT_STEP) expected_steps.push_back(directed_rows[i].want);
            else if (directed_rows[i].how == BY_MODEL && stepped) expected_steps.push_back(res);
         end
      end

      // Random rotations in phases of differing backoff
      phase_no = 0;
      while (random_items < RANDOM_ITEMS) begin
         case (phase_no)
            0: bo = 8'd0;
            1: bo = 8'hFF;
            2: bo = 8'd1;
            default: bo = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255))
                                                       : 8'($urandom_range(0, 12));
         endcase
         drain_steps();
         write_backoff(bo);
         phase_end = random_items + $urandom_range(80, 200);
         while (random_items < phase_end && random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) feed(random_item(KIND_TICK));
            run_rotation();
         end
         phase_no++;
      end

      drain_steps();
      if (fail_count == 0) $display("stepper_sector_indexer_tb: PASS");
      else $display("stepper_sector_indexer_tb: FAIL");
      $finish;
   end

   // Hang guard
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("stepper_sector_indexer_tb: FAIL");
      $finish;
   end

endmodule
